// ===== design/ssg_pkg.sv =====
// Shared types and constants for the spatial source gain block.
package ssg_pkg;

  localparam logic [15:0] UNITY = 16'h8000;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_MODE        = 3'd0,
    CFG_MIN_DIST    = 3'd1,
    CFG_MAX_DIST    = 3'd2,
    CFG_ROLLOFF     = 3'd3,
    CFG_INNER_COS   = 3'd4,
    CFG_OUTER_COS   = 3'd5,
    CFG_OUTER_GAIN  = 3'd6,
    CFG_GAIN_LIMITS = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODEL_NONE    = 2'd0,
    MODEL_INVERSE = 2'd1,
    MODEL_LINEAR  = 2'd2,
    MODEL_EXP     = 2'd3
  } model_t;

  typedef struct packed {
    logic [31:0]        distance;
    logic signed [15:0] facing_z;
  } ssg_in_t;

  typedef struct packed {
    logic [15:0] distance_gain;
    logic [15:0] angle_gain;
    logic [15:0] total_gain;
  } ssg_out_t;

  localparam int FRONT_STAGES = 6;
  localparam int DIV_STEPS    = 32;
  localparam int CONE_STEPS   = 16;
  localparam int SQRT_STEPS   = 32;
  localparam int SQRT_ROUNDS  = 8;
  localparam int SQ_TOTAL     = SQRT_STEPS * SQRT_ROUNDS;
  localparam int POW_STEPS    = 16;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + 1 + SQ_TOTAL + POW_STEPS + 2;

endpackage

// ===== design/spatial_source_gain.sv =====
// Top level: distance, cone and total gain of one positional source, fully pipelined.
//
// Input beats (in_valid/in_ready) carry a Q16.16 distance and the Q1.15 z of the
// direction toward the listener. Each input beat yields exactly one result beat
// (out_valid/out_ready) with distance, cone and total gain in Q1.15.
// Configuration writes (cfg_valid/cfg_ready, register index and data) are taken
// in every cycle; write them only while no item is in flight.
// One item enters per cycle while the pipeline is not held; the pipeline is a chain of
// a 32-step restoring divider, eight 32-step integer square roots (one root bit per stage)
// and a 16-step square-and-multiply with two 32x32 multipliers per stage.
// All items share one stage advance. The pipeline holds only when its last stage
// is full while the output register holds a beat that is not taken; until then
// new beats keep entering while a result waits.
// Synchronous reset empties the pipeline and the output register and loads the
// configuration defaults.
module spatial_source_gain (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssg_pkg::ssg_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ssg_pkg::ssg_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ssg_pkg::*;

  typedef struct packed {
    logic [31:0] c;
    logic [31:0] e;
    logic        ratio_zero;
    logic        interp;
    logic [15:0] ag_base;
    logic [15:0] dmo;
    logic [15:0] denc;
  } prep_t;

  typedef struct packed {
    logic [31:0] c;
    logic [47:0] re;
    logic [31:0] cprod;
    logic        ratio_zero;
    logic        interp;
    logic [15:0] ag_base;
    logic [15:0] denc;
  } mul_t;

  typedef struct packed {
    logic [31:0] c;
    logic [47:0] re;
    logic [48:0] d_inv;
    logic [31:0] range;
    logic [31:0] nc;
    logic        ratio_zero;
    logic        interp;
    logic [15:0] ag_base;
    logic [15:0] denc;
  } den_t;

  typedef struct packed {
    logic [63:0] num;
    logic [48:0] den;
    logic [31:0] nc;
    logic [15:0] denc;
    logic        zero_den;
    logic        ratio_zero;
    logic        lin_sat;
    logic        interp;
    logic [15:0] ag_base;
  } num_t;

  typedef struct packed {
    logic [48:0] rem;
    logic [31:0] lo;
    logic [31:0] q;
    logic [48:0] den;
    logic [15:0] crem;
    logic [15:0] clo;
    logic [15:0] cq;
    logic [15:0] denc;
    logic        zero_den;
    logic        ratio_zero;
    logic        lin_sat;
    logic        interp;
    logic [15:0] ag_base;
  } div_t;

  typedef struct packed {
    logic [15:0] dg;
    logic [15:0] ag;
    logic        exp_sel;
    logic [31:0] ratio;
  } post_t;

  typedef struct packed {
    logic [63:0] x;
    logic [33:0] rem;
    logic [31:0] root;
    logic [15:0] dg;
    logic [15:0] ag;
    logic        exp_sel;
  } sq_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [31:0] base;
    logic [15:0] dg;
    logic [15:0] ag;
    logic        exp_sel;
  } pow_t;

  typedef struct packed {
    logic [15:0] dg;
    logic [15:0] ag;
  } sel_t;

  typedef struct packed {
    logic [31:0] p;
    logic [15:0] dg;
    logic [15:0] ag;
  } prod_t;

  function automatic logic [15:0] sat_unity(logic [15:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

  function automatic div_t div_step(div_t s, logic cone);
    logic [49:0] r2;
    logic [16:0] c2;
    div_t        r;
    r    = s;
    r2   = {s.rem, s.lo[31]};
    r.lo = {s.lo[30:0], 1'b0};
    if (r2 >= {1'b0, s.den}) begin
      r.rem = 49'(r2 - {1'b0, s.den});
      r.q   = {s.q[30:0], 1'b1};
    end else begin
      r.rem = r2[48:0];
      r.q   = {s.q[30:0], 1'b0};
    end
    if (cone) begin
      c2    = {s.crem, s.clo[15]};
      r.clo = {s.clo[14:0], 1'b0};
      if (c2 >= {1'b0, s.denc}) begin
        r.crem = 16'(c2 - {1'b0, s.denc});
        r.cq   = {s.cq[14:0], 1'b1};
      end else begin
        r.crem = c2[15:0];
        r.cq   = {s.cq[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic sq_t sqrt_step(sq_t s);
    logic [35:0] rem2;
    logic [35:0] t;
    sq_t         r;
    r    = s;
    rem2 = {s.rem, s.x[63:62]};
    t    = {2'b00, s.root, 2'b01};
    r.x  = {s.x[61:0], 2'b00};
    if (rem2 >= t) begin
      r.rem  = 34'(rem2 - t);
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = rem2[33:0];
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // Configuration registers
  logic [2:0]  mode_r;
  logic [31:0] min_dist_r;
  logic [31:0] max_dist_r;
  logic [15:0] rolloff_r;
  logic [15:0] inner_cos_r;
  logic [15:0] outer_cos_r;
  logic [15:0] outer_gain_r;
  logic [31:0] gain_limits_r;

  logic                  adv;
  logic [NUM_STAGES-1:0] vld_r;

  ssg_in_t in_r;
  prep_t   pr_r, pr_nxt;
  mul_t    ml_r, ml_nxt;
  den_t    dn_r, dn_nxt;
  num_t    nm_r, nm_nxt;
  num_t    st_r, st_nxt;
  div_t    dv_r   [DIV_STEPS];
  div_t    dv_nxt [DIV_STEPS];
  post_t   po_r, po_nxt;
  sq_t     sq_r   [SQ_TOTAL];
  sq_t     sq_nxt [SQ_TOTAL];
  pow_t    pw_r   [POW_STEPS];
  pow_t    pw_nxt [POW_STEPS];
  sel_t    sl_r, sl_nxt;
  prod_t   mu_r, mu_nxt;

  ssg_out_t out_r, out_nxt;
  logic     out_valid_r;

  model_t model;
  logic   degen;

  assign model     = model_t'(mode_r[1:0]);
  assign degen     = (min_dist_r >= max_dist_r);
  assign cfg_ready = 1'b1;

  // Hold everything only when the last stage cannot drain into the output register
  assign adv      = !(vld_r[NUM_STAGES-1] && out_valid_r && !out_ready);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= 3'd0;
      min_dist_r    <= 32'd65536;
      max_dist_r    <= 32'd65536000;
      rolloff_r     <= 16'd256;
      inner_cos_r   <= 16'h8000;
      outer_cos_r   <= 16'h8000;
      outer_gain_r  <= 16'd0;
      gain_limits_r <= 32'h8000_0000;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:        mode_r        <= cfg_data[2:0];
        CFG_MIN_DIST:    min_dist_r    <= cfg_data;
        CFG_MAX_DIST:    max_dist_r    <= cfg_data;
        CFG_ROLLOFF:     rolloff_r     <= cfg_data[15:0];
        CFG_INNER_COS:   inner_cos_r   <= cfg_data[15:0];
        CFG_OUTER_COS:   outer_cos_r   <= cfg_data[15:0];
        CFG_OUTER_GAIN:  outer_gain_r  <= cfg_data[15:0];
        CFG_GAIN_LIMITS: gain_limits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_valid};
    end
  end

  // Clamp the distance and classify the cone angle
  always_comb begin
    logic signed [16:0] dot;
    logic signed [16:0] inner;
    logic signed [16:0] outer;
    logic signed [16:0] diff;
    logic [15:0]        g;
    logic               cone_on;
    dot   = 17'sd0 - $signed({in_r.facing_z[15], in_r.facing_z});
    inner = $signed({inner_cos_r[15], inner_cos_r});
    outer = $signed({outer_cos_r[15], outer_cos_r});
    diff  = dot - outer;
    g     = sat_unity(outer_gain_r);
    cone_on = mode_r[2] && (in_r.distance != 32'd0);
    if (in_r.distance < min_dist_r) begin
      pr_nxt.c = min_dist_r;
    end else if (in_r.distance > max_dist_r) begin
      pr_nxt.c = max_dist_r;
    end else begin
      pr_nxt.c = in_r.distance;
    end
    pr_nxt.e          = pr_nxt.c - min_dist_r;
    pr_nxt.ratio_zero = (min_dist_r == 32'd0) || (pr_nxt.c == 32'd0);
    pr_nxt.dmo        = diff[15:0];
    pr_nxt.denc       = 16'(inner - outer);
    if (!cone_on || dot > inner) begin
      pr_nxt.ag_base = UNITY;
      pr_nxt.interp  = 1'b0;
    end else if (dot <= outer) begin
      pr_nxt.ag_base = g;
      pr_nxt.interp  = 1'b0;
    end else begin
      pr_nxt.ag_base = g;
      pr_nxt.interp  = 1'b1;
    end
  end

  always_comb begin
    ml_nxt.c          = pr_r.c;
    ml_nxt.re         = 48'(rolloff_r) * 48'(pr_r.e);
    ml_nxt.cprod      = 32'(UNITY - sat_unity(outer_gain_r)) * 32'(pr_r.dmo);
    ml_nxt.ratio_zero = pr_r.ratio_zero;
    ml_nxt.interp     = pr_r.interp;
    ml_nxt.ag_base    = pr_r.ag_base;
    ml_nxt.denc       = pr_r.denc;
  end

  always_comb begin
    dn_nxt.c          = ml_r.c;
    dn_nxt.re         = ml_r.re;
    dn_nxt.d_inv      = 49'({min_dist_r, 8'h00}) + 49'(ml_r.re);
    dn_nxt.range      = max_dist_r - min_dist_r;
    dn_nxt.nc         = ml_r.cprod + 32'(ml_r.denc >> 1);
    dn_nxt.ratio_zero = ml_r.ratio_zero;
    dn_nxt.interp     = ml_r.interp;
    dn_nxt.ag_base    = ml_r.ag_base;
    dn_nxt.denc       = ml_r.denc;
  end

  // Pick dividend and divisor for the selected model; rounding offsets go in here
  always_comb begin
    nm_nxt.nc         = dn_r.nc;
    nm_nxt.denc       = dn_r.denc;
    nm_nxt.zero_den   = (dn_r.d_inv == 49'd0);
    nm_nxt.ratio_zero = dn_r.ratio_zero;
    nm_nxt.lin_sat    = 1'b0;
    nm_nxt.interp     = dn_r.interp;
    nm_nxt.ag_base    = dn_r.ag_base;
    case (model)
      MODEL_INVERSE: begin
        nm_nxt.num = 64'({min_dist_r, 23'd0}) + 64'(dn_r.d_inv >> 1);
        nm_nxt.den = dn_r.d_inv;
      end
      MODEL_LINEAR: begin
        nm_nxt.num = 64'({dn_r.re, 7'd0}) + 64'(dn_r.range >> 1);
        nm_nxt.den = 49'(dn_r.range);
      end
      default: begin
        nm_nxt.num = {1'b0, min_dist_r, 31'd0};
        nm_nxt.den = 49'(dn_r.c);
      end
    endcase
  end

  // Linear attenuation of one or more drives the gain to zero
  always_comb begin
    st_nxt         = nm_r;
    st_nxt.lin_sat = (nm_r.num >= {nm_r.den, 15'd0});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= in_data;
      pr_r <= pr_nxt;
      ml_r <= ml_nxt;
      dn_r <= dn_nxt;
      nm_r <= nm_nxt;
      st_r <= st_nxt;
      po_r <= po_nxt;
      sl_r <= sl_nxt;
      mu_r <= mu_nxt;
    end
  end

  // Restoring divider, one quotient bit per stage; the cone divide rides along
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    div_t dv_in;
    if (k == 0) begin : g_head
      always_comb begin
        dv_in.rem        = 49'(st_r.num[63:32]);
        dv_in.lo         = st_r.num[31:0];
        dv_in.q          = '0;
        dv_in.den        = st_r.den;
        dv_in.crem       = st_r.nc[31:16];
        dv_in.clo        = st_r.nc[15:0];
        dv_in.cq         = '0;
        dv_in.denc       = st_r.denc;
        dv_in.zero_den   = st_r.zero_den;
        dv_in.ratio_zero = st_r.ratio_zero;
        dv_in.lin_sat    = st_r.lin_sat;
        dv_in.interp     = st_r.interp;
        dv_in.ag_base    = st_r.ag_base;
      end
    end else begin : g_body
      assign dv_in = dv_r[k-1];
    end
    assign dv_nxt[k] = div_step(dv_in, (k < CONE_STEPS));
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  always_comb begin
    div_t dq;
    dq = dv_r[DIV_STEPS-1];
    case (model)
      MODEL_INVERSE: po_nxt.dg = dq.zero_den ? UNITY : dq.q[15:0];
      MODEL_LINEAR:  po_nxt.dg = dq.lin_sat ? 16'd0 : 16'(UNITY - dq.q[15:0]);
      default:       po_nxt.dg = UNITY;
    endcase
    if (degen) begin
      po_nxt.dg = UNITY;
    end
    po_nxt.exp_sel = (model == MODEL_EXP) && !degen;
    if (dq.ratio_zero) begin
      po_nxt.ratio = 32'd0;
    end else if (dq.q > 32'h8000_0000) begin
      po_nxt.ratio = 32'h8000_0000;
    end else begin
      po_nxt.ratio = dq.q;
    end
    po_nxt.ag = dq.interp ? 16'(dq.ag_base + dq.cq) : dq.ag_base;
  end

  // Eight chained square roots take the ratio to its 256th root
  for (genvar k = 0; k < SQ_TOTAL; k++) begin : g_sq
    sq_t sq_in;
    if (k == 0) begin : g_head
      always_comb begin
        sq_in         = '0;
        sq_in.x       = {1'b0, po_r.ratio, 31'd0};
        sq_in.dg      = po_r.dg;
        sq_in.ag      = po_r.ag;
        sq_in.exp_sel = po_r.exp_sel;
      end
    end else if (k % SQRT_STEPS == 0) begin : g_round
      always_comb begin
        sq_in      = sq_r[k-1];
        sq_in.x    = {1'b0, sq_r[k-1].root, 31'd0};
        sq_in.rem  = '0;
        sq_in.root = '0;
      end
    end else begin : g_body
      assign sq_in = sq_r[k-1];
    end
    assign sq_nxt[k] = sqrt_step(sq_in);
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k] <= sq_nxt[k];
      end
    end
  end

  // Raise the root to the rolloff, one exponent bit per stage
  for (genvar k = 0; k < POW_STEPS; k++) begin : g_pow
    pow_t        pw_in;
    logic [63:0] prod_ab;
    logic [63:0] prod_bb;
    if (k == 0) begin : g_head
      always_comb begin
        pw_in.acc     = 32'h8000_0000;
        pw_in.base    = sq_r[SQ_TOTAL-1].root;
        pw_in.dg      = sq_r[SQ_TOTAL-1].dg;
        pw_in.ag      = sq_r[SQ_TOTAL-1].ag;
        pw_in.exp_sel = sq_r[SQ_TOTAL-1].exp_sel;
      end
    end else begin : g_body
      assign pw_in = pw_r[k-1];
    end
    always_comb begin
      prod_ab        = 64'(pw_in.acc) * 64'(pw_in.base);
      prod_bb        = 64'(pw_in.base) * 64'(pw_in.base);
      pw_nxt[k]      = pw_in;
      pw_nxt[k].acc  = rolloff_r[k] ? prod_ab[62:31] : pw_in.acc;
      pw_nxt[k].base = prod_bb[62:31];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        pw_r[k] <= pw_nxt[k];
      end
    end
  end

  always_comb begin
    logic [32:0] acc_rnd;
    acc_rnd   = 33'(pw_r[POW_STEPS-1].acc) + 33'h0_0000_8000;
    sl_nxt.dg = pw_r[POW_STEPS-1].exp_sel ? acc_rnd[31:16] : pw_r[POW_STEPS-1].dg;
    sl_nxt.ag = pw_r[POW_STEPS-1].ag;
  end

  always_comb begin
    mu_nxt.p  = 32'(sl_r.dg) * 32'(sl_r.ag);
    mu_nxt.dg = sl_r.dg;
    mu_nxt.ag = sl_r.ag;
  end

  always_comb begin
    logic [31:0] tsum;
    logic [15:0] tot;
    logic [15:0] lo;
    logic [15:0] hi;
    tsum = mu_r.p + 32'd16384;
    tot  = tsum[30:15];
    lo   = sat_unity(gain_limits_r[15:0]);
    hi   = sat_unity(gain_limits_r[31:16]);
    if (tot < lo) begin
      tot = lo;
    end
    if (tot > hi) begin
      tot = hi;
    end
    out_nxt.distance_gain = mu_r.dg;
    out_nxt.angle_gain    = mu_r.ag;
    out_nxt.total_gain    = tot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && vld_r[NUM_STAGES-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[NUM_STAGES-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/ssg_checker.sv =====
// Port-level checker for the spatial source gain block, with its bind.
module ssg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ssg_pkg::ssg_out_t  out_data
);
  import ssg_pkg::*;

  localparam int CNT_W = $clog2(NUM_STAGES + 2);

  logic [CNT_W-1:0] pend_r, pend_nxt;
  logic             in_beat;
  logic             out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_beat && !out_beat) begin
      pend_nxt = pend_r + CNT_W'(1);
    end else if (out_beat && !in_beat) begin
      pend_nxt = pend_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown after reset");

  // No result beat without an accepted input beat behind it
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result beat without pending input");

  // An empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held while output empty");

endmodule

bind spatial_source_gain ssg_checker u_ssg_checker (.*);
